[hw/rtl/ttr_pkg.sv]
// ----------------------------------------------------------------------------
// ttr_pkg
// Shared geometry, character codes, register map and helpers of the text
// terminal renderer.
// ----------------------------------------------------------------------------
package ttr_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;

  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_LBR = 8'h5b;
  localparam logic [7:0] CH_M   = 8'h6d;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_DFG  = 2'd2;
  localparam logic [1:0] REG_DBG  = 2'd3;

  localparam logic [7:0] COLS_RST = 8'd80;
  localparam logic [6:0] ROWS_RST = 7'd24;
  localparam logic [3:0] DFG_RST  = 4'd15;
  localparam logic [3:0] DBG_RST  = 4'd0;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;
  localparam logic [1:0] PH_NUM  = 2'd3;

  typedef struct packed {
    logic [7:0] nc;       // effective columns, 1..MAX_COLS
    logic [6:0] nr;       // effective rows, 1..MAX_ROWS
    logic [3:0] dfg;
    logic [3:0] dbg;
    logic       geom_wr;  // columns or rows written this cycle
    logic [7:0] nc_new;
    logic [6:0] nr_new;
  } cfg_t;

  function automatic logic [7:0] eff_cols(input logic [7:0] v);
    if (v == 8'd0) return 8'd1;
    if (int'(v) > MAX_COLS) return 8'(MAX_COLS);
    return v;
  endfunction

  function automatic logic [6:0] eff_rows(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (int'(v) > MAX_ROWS) return 7'(MAX_ROWS);
    return v;
  endfunction

  function automatic logic [2:0] ansi_to_vga(input logic [2:0] a);
    logic [2:0] r;
    case (a)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [6:0] c, input logic [6:0] r);
    logic [COL_W-1:0] cc;
    logic [ROW_W-1:0] rr;
    cc = (int'(c) >= MAX_COLS) ? COL_W'(MAX_COLS - 1) : c[COL_W-1:0];
    rr = (int'(r) >= MAX_ROWS) ? ROW_W'(MAX_ROWS - 1) : r[ROW_W-1:0];
    return {rr, cc};
  endfunction

endpackage

[hw/rtl/ttr_ram.sv]
// ----------------------------------------------------------------------------
// ttr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ttr_regs.sv]
// ----------------------------------------------------------------------------
// ttr_regs
// APB register file: window geometry and default colours.
// ----------------------------------------------------------------------------
module ttr_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ttr_pkg::cfg_t    cfg_o
);

  logic [7:0] cols_q;
  logic [6:0] rows_q;
  logic [3:0] dfg_q, dbg_q;
  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ttr_pkg::COLS_RST;
      rows_q <= ttr_pkg::ROWS_RST;
      dfg_q  <= ttr_pkg::DFG_RST;
      dbg_q  <= ttr_pkg::DBG_RST;
    end else if (wr) begin
      unique case (idx)
        ttr_pkg::REG_COLS: cols_q <= pwdata[7:0];
        ttr_pkg::REG_ROWS: rows_q <= pwdata[6:0];
        ttr_pkg::REG_DFG:  dfg_q  <= pwdata[3:0];
        default:           dbg_q  <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ttr_pkg::REG_COLS: prdata = {24'd0, cols_q};
      ttr_pkg::REG_ROWS: prdata = {25'd0, rows_q};
      ttr_pkg::REG_DFG:  prdata = {28'd0, dfg_q};
      default:           prdata = {28'd0, dbg_q};
    endcase
  end

  always_comb begin
    cfg_o.nc      = ttr_pkg::eff_cols(cols_q);
    cfg_o.nr      = ttr_pkg::eff_rows(rows_q);
    cfg_o.dfg     = dfg_q;
    cfg_o.dbg     = dbg_q;
    cfg_o.geom_wr = wr && (idx == ttr_pkg::REG_COLS || idx == ttr_pkg::REG_ROWS);
    cfg_o.nc_new  = (idx == ttr_pkg::REG_COLS) ? ttr_pkg::eff_cols(pwdata[7:0]) : cfg_o.nc;
    cfg_o.nr_new  = (idx == ttr_pkg::REG_ROWS) ? ttr_pkg::eff_rows(pwdata[6:0]) : cfg_o.nr;
  end

endmodule

[hw/rtl/ttr_core.sv]
// ----------------------------------------------------------------------------
// ttr_core
// Escape parser, cursor control and glyph store sequencer.
// ----------------------------------------------------------------------------
module ttr_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ttr_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 ch_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       kind_o,
  output logic [6:0]                 col_o,
  output logic [5:0]                 row_o,
  output logic [7:0]                 glyph_o,
  output logic [3:0]                 fg_o,
  output logic [3:0]                 bg_o,
  output logic                       last_o,
  output logic                       we_o,
  output logic [ttr_pkg::ADDR_W-1:0] waddr_o,
  output logic [7:0]                 wdata_o,
  output logic [ttr_pkg::ADDR_W-1:0] raddr_o,
  input  logic [7:0]                 rdata_i
);

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_TEXT   = 4'd2;
  localparam logic [3:0] ST_BS_RD  = 4'd3;
  localparam logic [3:0] ST_BS_CHK = 4'd4;
  localparam logic [3:0] ST_PUT    = 4'd5;
  localparam logic [3:0] ST_SC_CP  = 4'd6;
  localparam logic [3:0] ST_SC_FL  = 4'd7;
  localparam logic [3:0] ST_SC_BL  = 4'd8;

  localparam int AW = ttr_pkg::ADDR_W;
  localparam int CW = ttr_pkg::COL_W;
  localparam int RW = ttr_pkg::ROW_W;

  logic [3:0]    st_q, st_d;
  logic [7:0]    ch_q, ch_d;
  logic [1:0]    ph_q, ph_d;
  logic [7:0]    num_q, num_d;
  logic [3:0]    fg_q, fg_d, bg_q, bg_d;
  logic [6:0]    ccol_q, ccol_d, crow_q, crow_d;
  logic          moved_q, moved_d;
  logic          adv_q, adv_d;
  logic [7:0]    pg_q, pg_d;
  logic          ret_q, ret_d;   // after the sweep: 1 back to text handling
  logic [RW-1:0] sr_q, sr_d;
  logic [CW-1:0] sc_q, sc_d;
  logic          wp_q, wp_d;
  logic [AW-1:0] wa_q, wa_d;
  logic [AW-1:0] clr_q, clr_d;

  logic          ov_q, ov_d;
  logic          ok_q, ok_d, ol_q, ol_d;
  logic [6:0]    oc_q, oc_d;
  logic [5:0]    or_q, or_d;
  logic [7:0]    og_q, og_d;
  logic [3:0]    of_q, of_d, ob_q, ob_d;

  logic          can_emit;
  logic          is_dig;
  logic [3:0]    dig;
  logic [11:0]   num_x10;
  logic [7:0]    last_col;
  logic [6:0]    row_n;

  assign can_emit   = !ov_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE);
  assign is_dig     = (ch_i >= ttr_pkg::CH_0) && (ch_i <= ttr_pkg::CH_9);
  assign dig        = 4'(ch_i - ttr_pkg::CH_0);
  assign num_x10    = {4'd0, num_q} * 12'd10 + {8'd0, dig};
  assign last_col   = cfg_i.nc - 8'd1;
  assign row_n      = crow_q + 7'd1;

  always_comb begin
    st_d = st_q; ch_d = ch_q; ph_d = ph_q; num_d = num_q;
    fg_d = fg_q; bg_d = bg_q; ccol_d = ccol_q; crow_d = crow_q;
    moved_d = moved_q; adv_d = adv_q; pg_d = pg_q; ret_d = ret_q;
    sr_d = sr_q; sc_d = sc_q; wp_d = wp_q; wa_d = wa_q; clr_d = clr_q;
    ov_d = ov_q && !out_ready_i;
    ok_d = ok_q; ol_d = ol_q; oc_d = oc_q; or_d = or_q; og_d = og_q;
    of_d = of_q; ob_d = ob_q;
    we_o = 1'b0; waddr_o = wa_q; wdata_o = rdata_i;
    raddr_o = ttr_pkg::cell_addr(ccol_q, crow_q);

    if (cfg_i.geom_wr) begin
      if ({1'b0, ccol_q} >= cfg_i.nc_new) ccol_d = 7'(cfg_i.nc_new - 8'd1);
      if (crow_q > cfg_i.nr_new) crow_d = cfg_i.nr_new;
    end

    unique case (st_q)
      ST_CLR: begin
        we_o = 1'b1; waddr_o = clr_q; wdata_o = ttr_pkg::CH_SP;
        clr_d = clr_q + AW'(1);
        if (&clr_q) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d = ch_i;
          unique case (ph_q)
            ttr_pkg::PH_ESC: begin
              if (ch_i == ttr_pkg::CH_LBR) ph_d = ttr_pkg::PH_CSI;
              else begin
                ph_d = ttr_pkg::PH_TEXT; st_d = ST_TEXT;
              end
            end
            ttr_pkg::PH_CSI: begin
              if (is_dig) begin
                num_d = {4'd0, dig}; ph_d = ttr_pkg::PH_NUM;
              end else begin
                ph_d = ttr_pkg::PH_TEXT; st_d = ST_TEXT;
              end
            end
            ttr_pkg::PH_NUM: begin
              if (is_dig) begin
                num_d = (num_x10 > 12'd255) ? 8'd255 : num_x10[7:0];
              end else begin
                ph_d = ttr_pkg::PH_TEXT;
                if (ch_i == ttr_pkg::CH_M) begin
                  if (num_q == 8'd0) begin
                    fg_d = cfg_i.dfg; bg_d = cfg_i.dbg;
                  end else if (num_q == 8'd39) fg_d = cfg_i.dfg;
                  else if (num_q == 8'd49) bg_d = cfg_i.dbg;
                  else if (num_q >= 8'd30 && num_q <= 8'd37)
                    fg_d = {1'b0, ttr_pkg::ansi_to_vga(3'(num_q - 8'd30))};
                  else if (num_q >= 8'd90 && num_q <= 8'd97)
                    fg_d = {1'b1, ttr_pkg::ansi_to_vga(3'(num_q - 8'd90))};
                  else if (num_q >= 8'd40 && num_q <= 8'd47)
                    bg_d = {1'b0, ttr_pkg::ansi_to_vga(3'(num_q - 8'd40))};
                  else if (num_q >= 8'd100 && num_q <= 8'd107)
                    bg_d = {1'b1, ttr_pkg::ansi_to_vga(3'(num_q - 8'd100))};
                end
              end
            end
            default: st_d = ST_TEXT;
          endcase
        end
      end
      ST_TEXT: begin
        if (crow_q >= cfg_i.nr) begin
          // pending scroll from a wrap on the last row
          if (can_emit) begin
            ov_d = 1'b1; ok_d = 1'b1; oc_d = '0; or_d = '0; og_d = ttr_pkg::CH_SP;
            of_d = fg_q; ob_d = bg_q;
            ol_d = (ch_q == ttr_pkg::CH_CR) || (ch_q == ttr_pkg::CH_ESC);
            crow_d = crow_q - 7'd1; ret_d = 1'b1;
            sc_d = '0; wp_d = 1'b0;
            if (cfg_i.nr > 7'd1) begin
              sr_d = '0; st_d = ST_SC_CP;
            end else begin
              sr_d = RW'(cfg_i.nr - 7'd1); st_d = ST_SC_BL;
            end
          end
        end else begin
          case (ch_q)
            ttr_pkg::CH_LF: begin
              if (row_n >= cfg_i.nr) begin
                if (can_emit) begin
                  ov_d = 1'b1; ok_d = 1'b1; oc_d = '0; or_d = '0;
                  og_d = ttr_pkg::CH_SP; of_d = fg_q; ob_d = bg_q; ol_d = 1'b1;
                  ccol_d = '0; ret_d = 1'b0; sc_d = '0; wp_d = 1'b0;
                  if (cfg_i.nr > 7'd1) begin
                    sr_d = '0; st_d = ST_SC_CP;
                  end else begin
                    sr_d = RW'(cfg_i.nr - 7'd1); st_d = ST_SC_BL;
                  end
                end
              end else begin
                crow_d = row_n; ccol_d = '0; st_d = ST_IDLE;
              end
            end
            ttr_pkg::CH_CR: begin
              ccol_d = '0; st_d = ST_IDLE;
            end
            ttr_pkg::CH_ESC: begin
              ph_d = ttr_pkg::PH_ESC; st_d = ST_IDLE;
            end
            ttr_pkg::CH_BS: begin
              pg_d = ttr_pkg::CH_SP; adv_d = 1'b0;
              if (ccol_q != 7'd0) begin
                ccol_d = ccol_q - 7'd1; st_d = ST_PUT;
              end else begin
                ccol_d = last_col[6:0];
                if (crow_q != 7'd0) crow_d = crow_q - 7'd1;
                moved_d = 1'b0; st_d = ST_BS_RD;
              end
            end
            default: begin
              pg_d = ch_q; adv_d = 1'b1; st_d = ST_PUT;
            end
          endcase
        end
      end
      ST_BS_RD: st_d = ST_BS_CHK;
      ST_BS_CHK: begin
        if (rdata_i == ttr_pkg::CH_SP && ccol_q != 7'd0) begin
          ccol_d = ccol_q - 7'd1; moved_d = 1'b1; st_d = ST_BS_RD;
        end else begin
          if (moved_q) ccol_d = ccol_q + 7'd1;
          st_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (can_emit) begin
          we_o = 1'b1; waddr_o = ttr_pkg::cell_addr(ccol_q, crow_q); wdata_o = pg_q;
          ov_d = 1'b1; ok_d = 1'b0; oc_d = ccol_q; or_d = crow_q[5:0]; og_d = pg_q;
          of_d = fg_q; ob_d = bg_q; ol_d = 1'b1;
          if (adv_q) begin
            if ({1'b0, ccol_q} + 8'd1 >= cfg_i.nc) begin
              ccol_d = '0; crow_d = row_n;
            end else ccol_d = ccol_q + 7'd1;
          end
          st_d = ST_IDLE;
        end
      end
      ST_SC_CP: begin
        // read row below, write the previous beat into the row above
        raddr_o = {sr_q + RW'(1), sc_q};
        we_o = wp_q; waddr_o = wa_q; wdata_o = rdata_i;
        wp_d = 1'b1; wa_d = {sr_q, sc_q};
        if ({1'b0, sc_q} == last_col) begin
          sc_d = '0;
          if ({1'b0, sr_q} == cfg_i.nr - 7'd2) st_d = ST_SC_FL;
          else sr_d = sr_q + RW'(1);
        end else sc_d = sc_q + CW'(1);
      end
      ST_SC_FL: begin
        we_o = wp_q; waddr_o = wa_q; wdata_o = rdata_i;
        wp_d = 1'b0; sc_d = '0; sr_d = RW'(cfg_i.nr - 7'd1); st_d = ST_SC_BL;
      end
      ST_SC_BL: begin
        we_o = 1'b1; waddr_o = {sr_q, sc_q}; wdata_o = ttr_pkg::CH_SP;
        if ({1'b0, sc_q} == last_col) st_d = ret_q ? ST_TEXT : ST_IDLE;
        else sc_d = sc_q + CW'(1);
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLR; ph_q <= ttr_pkg::PH_TEXT; num_q <= '0;
      fg_q <= ttr_pkg::DFG_RST; bg_q <= ttr_pkg::DBG_RST;
      ccol_q <= '0; crow_q <= '0; clr_q <= '0; wp_q <= 1'b0; ov_q <= 1'b0;
      ret_q <= 1'b0; moved_q <= 1'b0; adv_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; num_q <= num_d; fg_q <= fg_d; bg_q <= bg_d;
      ccol_q <= ccol_d; crow_q <= crow_d; clr_q <= clr_d; wp_q <= wp_d; ov_q <= ov_d;
      ret_q <= ret_d; moved_q <= moved_d; adv_q <= adv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; pg_q <= pg_d; sr_q <= sr_d; sc_q <= sc_d; wa_q <= wa_d;
    ok_q <= ok_d; ol_q <= ol_d; oc_q <= oc_d; or_q <= or_d; og_q <= og_d;
    of_q <= of_d; ob_q <= ob_d;
  end

  assign out_valid_o = ov_q;
  assign kind_o  = ok_q;
  assign col_o   = oc_q;
  assign row_o   = or_q;
  assign glyph_o = og_q;
  assign fg_o    = of_q;
  assign bg_o    = ob_q;
  assign last_o  = ol_q;

  a_cursor_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> ({1'b0, ccol_q} < cfg_i.nc && crow_q <= cfg_i.nr))
    else $error("cursor outside window while idle");

  a_sweep_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SC_CP) |-> ({1'b0, sr_q} + 7'd1 < cfg_i.nr))
    else $error("scroll copy beyond last row");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(og_q) && $stable(ok_q)))
    else $error("pending result overwritten");

  a_flush_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SC_FL) |-> wp_q)
    else $error("scroll flush without pending write");

endmodule

[hw/rtl/text_terminal_renderer_unit.sv]
// ----------------------------------------------------------------------------
// text_terminal_renderer_unit
// Console byte stream to text-grid cell writes and scroll commands.
// ----------------------------------------------------------------------------
// One byte per input beat; each byte gives zero, one or two result beats.
// Backspace at column 0 walks the row through the glyph store read port.
// A scroll copies the window in the glyph store one cell per cycle. After
// reset a clearing pass fills the store with spaces and no byte is taken
// meanwhile; configuration writes are accepted always.
module text_terminal_renderer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [6:0]  col_o,
  output logic [5:0]  row_o,
  output logic [7:0]  glyph_o,
  output logic [3:0]  fg_o,
  output logic [3:0]  bg_o,
  output logic        last_o
);

  ttr_pkg::cfg_t                 cfg;
  logic                          we;
  logic [ttr_pkg::ADDR_W-1:0]    waddr, raddr;
  logic [7:0]                    wdata, rdata;

  ttr_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  ttr_ram #(.WIDTH(8), .DEPTH(ttr_pkg::DEPTH)) u_glyphs (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  ttr_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i, .in_ready_o, .ch_i,
    .out_valid_o, .out_ready_i, .kind_o, .col_o, .row_o, .glyph_o,
    .fg_o, .bg_o, .last_o,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

endmodule
